// ===== src/t3blur_pkg.sv =====
`timescale 1ns / 1ps

package t3blur_pkg;

	localparam int DEF_MAX_HEIGHT = 16;
	localparam int DEF_MAX_WIDTH  = 16;

	localparam int DIM_W   = 5;
	localparam int COORD_W = 4;
	localparam int DATA_W  = 16;
	localparam int WGT_W   = 17;
	localparam int ACC_W   = 21;
	localparam int IDX_W   = 2;

	localparam logic [DIM_W-1:0]  RST_GRID_HEIGHT = 5'd16;
	localparam logic [DIM_W-1:0]  RST_GRID_WIDTH  = 5'd16;
	localparam logic [DATA_W-1:0] RST_BLUR_AMOUNT = 16'd7864;

	// floor(b/6) for any 16-bit b as (b * 43691) >> 18
	localparam logic [DATA_W-1:0] DIV6_MULT  = 16'd43691;
	localparam int                DIV6_SHIFT = 18;

	localparam logic [WGT_W-1:0]  ONE_Q16 = 17'h10000;
	localparam logic [DATA_W-1:0] SAT_MAX = 16'hFFFF;

	typedef enum logic [IDX_W-1:0] {
		CFG_GRID_HEIGHT = 2'd0,
		CFG_GRID_WIDTH  = 2'd1,
		CFG_BLUR_AMOUNT = 2'd2,
		CFG_UNUSED      = 2'd3
	} cfg_idx_t;

	typedef enum logic {
		ACT_WRITE = 1'b0,
		ACT_READ  = 1'b1
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_DRAIN1,
		ST_DRAIN2,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic start;
		logic issue;
		logic load;
	} cmd_t;

	typedef struct packed {
		logic rd_go;
		logic last;
		logic out_free;
	} status_t;

endpackage

// ===== src/t3blur_ctrl.sv =====
`timescale 1ns / 1ps

module t3blur_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  t3blur_pkg::status_t sts,
	output t3blur_pkg::cmd_t    cmd
);
	import t3blur_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid && sts.rd_go) begin
					state_nxt = ST_READ;
				end
			end
			ST_READ: begin
				if (sts.last) begin
					state_nxt = ST_DRAIN1;
				end
			end
			ST_DRAIN1: state_nxt = ST_DRAIN2;
			ST_DRAIN2: state_nxt = ST_FINISH;
			ST_FINISH: begin
				if (sts.out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		cmd       = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.start = in_valid;
			end
			ST_READ:   cmd.issue = 1'b1;
			ST_DRAIN1: ;
			ST_DRAIN2: ;
			ST_FINISH: cmd.load = sts.out_free;
			default: ;
		endcase
	end

endmodule

// ===== src/t3blur_dp.sv =====
`timescale 1ns / 1ps

module t3blur_dp #(
	parameter int MAX_HEIGHT = t3blur_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_WIDTH  = t3blur_pkg::DEF_MAX_WIDTH
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	input  logic [t3blur_pkg::IDX_W-1:0]     cfg_index,
	input  logic [t3blur_pkg::DATA_W-1:0]    cfg_data,
	input  logic                             action,
	input  logic [t3blur_pkg::COORD_W-1:0]   row,
	input  logic [t3blur_pkg::COORD_W-1:0]   col,
	input  logic [t3blur_pkg::DATA_W-1:0]    cell_value,
	input  t3blur_pkg::cmd_t                 cmd,
	output t3blur_pkg::status_t              sts,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [t3blur_pkg::COORD_W-1:0]   out_row,
	output logic [t3blur_pkg::COORD_W-1:0]   out_col,
	output logic [t3blur_pkg::DATA_W-1:0]    blurred_value
);
	import t3blur_pkg::*;

	localparam int DEPTH = MAX_HEIGHT * MAX_WIDTH;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// configuration
	logic [DIM_W-1:0]  height_q;
	logic [DIM_W-1:0]  width_q;
	logic [DATA_W-1:0] blur_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= RST_GRID_HEIGHT;
			width_q  <= RST_GRID_WIDTH;
			blur_q   <= RST_BLUR_AMOUNT;
		end else if (cfg_valid) begin
			case (cfg_idx_t'(cfg_index))
				CFG_GRID_HEIGHT: height_q <= cfg_data[DIM_W-1:0];
				CFG_GRID_WIDTH:  width_q  <= cfg_data[DIM_W-1:0];
				CFG_BLUR_AMOUNT: blur_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// weights reg blur_q; user moves config only while idle, not enforced
	logic [31:0]       div6_prod;
	logic [DATA_W-1:0] adj_q;
	logic [DATA_W-1:0] corner_q;
	logic [WGT_W-1:0]  center_q;

	assign div6_prod = blur_q * DIV6_MULT;

	always_ff @(posedge clk) begin
		adj_q    <= DATA_W'(div6_prod >> DIV6_SHIFT);
		corner_q <= DATA_W'(div6_prod >> (DIV6_SHIFT + 1));
		center_q <= ONE_Q16 - {1'b0, blur_q};
	end

	// grid size in use
	logic [DIM_W-1:0] h_use;
	logic [DIM_W-1:0] w_use;

	always_comb begin
		if (height_q == '0) begin
			h_use = DIM_W'(1);
		end else if (32'(height_q) > MAX_HEIGHT) begin
			h_use = DIM_W'(MAX_HEIGHT);
		end else begin
			h_use = height_q;
		end
		if (width_q == '0) begin
			w_use = DIM_W'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			w_use = DIM_W'(MAX_WIDTH);
		end else begin
			w_use = width_q;
		end
	end

	logic [DIM_W-1:0] row_x;
	logic [DIM_W-1:0] col_x;
	logic             in_range;

	assign row_x    = {1'b0, row};
	assign col_x    = {1'b0, col};
	assign in_range = (row_x < h_use) && (col_x < w_use);

	assign sts.rd_go = in_range && (action_t'(action) == ACT_READ);

	// wrapped neighbour coordinates, latched at accept
	logic [DIM_W-1:0]   rs_q [3];
	logic [DIM_W-1:0]   cs_q [3];
	logic [COORD_W-1:0] row_q;
	logic [COORD_W-1:0] col_q;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			row_q <= row;
			col_q <= col;
			rs_q[0] <= (row_x == '0) ? h_use - DIM_W'(1) : row_x - DIM_W'(1);
			rs_q[1] <= row_x;
			rs_q[2] <= (row_x + DIM_W'(1) == h_use) ? '0 : row_x + DIM_W'(1);
			cs_q[0] <= (col_x == '0) ? w_use - DIM_W'(1) : col_x - DIM_W'(1);
			cs_q[1] <= col_x;
			cs_q[2] <= (col_x + DIM_W'(1) == w_use) ? '0 : col_x + DIM_W'(1);
		end
	end

	// window walk: a_q picks the row, k_q the column
	logic [1:0] a_q;
	logic [1:0] k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= '0;
			k_q <= '0;
		end else if (cmd.start) begin
			a_q <= '0;
			k_q <= '0;
		end else if (cmd.issue) begin
			if (k_q == 2'd2) begin
				k_q <= '0;
				a_q <= (a_q == 2'd2) ? 2'd0 : a_q + 2'd1;
			end else begin
				k_q <= k_q + 2'd1;
			end
		end
	end

	assign sts.last = (a_q == 2'd2) && (k_q == 2'd2);

	// single-port store
	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DIM_W-1:0]  cur_r;
	logic [DIM_W-1:0]  cur_c;
	logic [AW-1:0]     rd_addr;
	logic [AW-1:0]     wr_addr;
	logic              wr_en;

	assign cur_r   = rs_q[a_q];
	assign cur_c   = cs_q[k_q];
	assign rd_addr = AW'(32'(cur_r) * MAX_WIDTH + 32'(cur_c));
	assign wr_addr = AW'(32'(row_x) * MAX_WIDTH + 32'(col_x));
	assign wr_en   = cmd.start && in_range && (action_t'(action) == ACT_WRITE);

	logic [DATA_W-1:0] rd_s1;
	logic [WGT_W-1:0]  wgt_s1;
	logic              v_s1;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= cell_value;
		end
		if (cmd.issue) begin
			rd_s1 <= mem_q[rd_addr];
		end
	end

	// centre where both indices are middle, edge-adjacent where one is
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			if (a_q == 2'd1 && k_q == 2'd1) begin
				wgt_s1 <= center_q;
			end else if (a_q == 2'd1 || k_q == 2'd1) begin
				wgt_s1 <= {1'b0, adj_q};
			end else begin
				wgt_s1 <= {1'b0, corner_q};
			end
		end
	end

	logic [DATA_W+WGT_W-1:0] prod;
	logic [WGT_W-1:0]        term_s2;
	logic                    v_s2;
	logic [ACC_W-1:0]        acc_q;

	assign prod = rd_s1 * wgt_s1;

	always_ff @(posedge clk) begin
		term_s2 <= prod[DATA_W+WGT_W-1:16];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + ACC_W'(term_s2);
		end
	end

	// result register
	logic               out_valid_q;
	logic [COORD_W-1:0] out_row_q;
	logic [COORD_W-1:0] out_col_q;
	logic [DATA_W-1:0]  out_val_q;

	assign sts.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_row_q <= row_q;
			out_col_q <= col_q;
			out_val_q <= (acc_q > ACC_W'(SAT_MAX)) ? SAT_MAX : acc_q[DATA_W-1:0];
		end
	end

	assign out_valid     = out_valid_q;
	assign out_row       = out_row_q;
	assign out_col       = out_col_q;
	assign blurred_value = out_val_q;

endmodule

// ===== src/toroidal_3x3_blur_core.sv =====
`timescale 1ns / 1ps

// 3x3 weighted blur over a wraparound grid of Q0.16 cells held in a single-port
// store of MAX_HEIGHT*MAX_WIDTH words. A write request (action 0) stores one
// cell and is taken while the block is idle. A read request (action 1) gathers the nine
// neighbours one store read per cycle, weights them (centre 1-b, edge b/6,
// corner b/12, products truncated) and returns the saturated sum. The next
// request is taken only after the nine reads of the single store port, the
// two-stage multiply/accumulate pipe and the result load are through. The
// result sits in an output register, so a new request can be taken while it
// waits. Requests outside the grid in use are dropped without a result.
// Registers: 0 grid_height, 1 grid_width, 2 blur_amount; write only while idle.
// Cells must be written before they are read, also as neighbours.

module toroidal_3x3_blur_core #(
	parameter int MAX_HEIGHT = t3blur_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_WIDTH  = t3blur_pkg::DEF_MAX_WIDTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [t3blur_pkg::IDX_W-1:0]   cfg_index,
	input  logic [t3blur_pkg::DATA_W-1:0]  cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic                           action,
	input  logic [t3blur_pkg::COORD_W-1:0] row,
	input  logic [t3blur_pkg::COORD_W-1:0] col,
	input  logic [t3blur_pkg::DATA_W-1:0]  cell_value,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [t3blur_pkg::COORD_W-1:0] out_row,
	output logic [t3blur_pkg::COORD_W-1:0] out_col,
	output logic [t3blur_pkg::DATA_W-1:0]  blurred_value
);
	import t3blur_pkg::*;

	cmd_t    cmd;
	status_t sts;

	assign cfg_ready = 1'b1;

	t3blur_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	t3blur_dp #(
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_WIDTH  (MAX_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.action        (action),
		.row           (row),
		.col           (col),
		.cell_value    (cell_value),
		.cmd           (cmd),
		.sts           (sts),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.out_row       (out_row),
		.out_col       (out_col),
		.blurred_value (blurred_value)
	);

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
	import t3blur_pkg::*;

	localparam int GRID_ROWS    = DEF_MAX_HEIGHT;
	localparam int GRID_COLS    = DEF_MAX_WIDTH;
	localparam int PHASE_ITEMS  = 115;
	localparam int SETTLE_TICKS = 20;
	localparam int CYCLE_LIMIT  = 500000;

	typedef struct packed {
		logic [COORD_W-1:0] rw;
		logic [COORD_W-1:0] cl;
		logic [DATA_W-1:0]  blurred;
	} blur_result_t;

	typedef struct {
		bit                 is_reg;
		cfg_idx_t           idx;
		logic [DATA_W-1:0]  data;
		action_t            act;
		logic [COORD_W-1:0] r;
		logic [COORD_W-1:0] c;
		logic [DATA_W-1:0]  v;
		bit                 typed;
		logic [DATA_W-1:0]  typed_val;
	} step_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [IDX_W-1:0]    cfg_index;
	logic [DATA_W-1:0]   cfg_data;
	logic                in_valid;
	logic                in_ready;
	logic                action;
	logic [COORD_W-1:0]  row;
	logic [COORD_W-1:0]  col;
	logic [DATA_W-1:0]   cell_value;
	logic                out_valid;
	logic                out_ready;
	logic [COORD_W-1:0]  out_row;
	logic [COORD_W-1:0]  out_col;
	logic [DATA_W-1:0]   blurred_value;

	// shadow of the block's state
	logic [DIM_W-1:0]    rows_q;
	logic [DIM_W-1:0]    cols_q;
	logic [DATA_W-1:0]   blur_q;
	logic [DATA_W-1:0]   cell_mem [GRID_ROWS*GRID_COLS];

	blur_result_t        blur_expect [$];
	step_t               directed [$];
	int                  fails;
	int                  cycles;
	int                  send_idle_pct;
	int                  recv_idle_pct;

	toroidal_3x3_blur_core u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.row          (row),
		.col          (col),
		.cell_value   (cell_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_row      (out_row),
		.out_col      (out_col),
		.blurred_value(blurred_value)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int dim_in_use(input logic [DIM_W-1:0] d, input int lim);
		if (d == 0)
			return 1;
		if (d > lim)
			return lim;
		return int'(d);
	endfunction

	function automatic void add_req(input action_t a, input int r, input int c, input int v,
			input bit typed = 1'b0, input int tv = 0);
		step_t s;
		s.is_reg    = 1'b0;
		s.idx       = CFG_UNUSED;
		s.data      = '0;
		s.act       = a;
		s.r         = COORD_W'(r);
		s.c         = COORD_W'(c);
		s.v         = DATA_W'(v);
		s.typed     = typed;
		s.typed_val = DATA_W'(tv);
		directed.push_back(s);
	endfunction

	function automatic void add_reg(input cfg_idx_t idx, input int data);
		step_t s;
		s.is_reg    = 1'b1;
		s.idx       = idx;
		s.data      = DATA_W'(data);
		s.act       = ACT_WRITE;
		s.r         = '0;
		s.c         = '0;
		s.v         = '0;
		s.typed     = 1'b0;
		s.typed_val = '0;
		directed.push_back(s);
	endfunction

	// shadows writes; reads queue the blur of the wrapped 3x3
	task automatic predict_blur(input action_t act, input logic [COORD_W-1:0] r,
			input logic [COORD_W-1:0] c, input logic [DATA_W-1:0] v,
			input bit typed, input logic [DATA_W-1:0] typed_val);
		int                  h;
		int                  w;
		int                  rr [3];
		int                  cc [3];
		int                  kind;
		longint unsigned     wt [3];
		longint unsigned     acc;
		blur_result_t        res;
		h = dim_in_use(rows_q, GRID_ROWS);
		w = dim_in_use(cols_q, GRID_COLS);
		if (r >= h || c >= w)
			return;
		if (act == ACT_WRITE) begin
			cell_mem[r*GRID_COLS + c] = v;
			return;
		end
		wt[0] = blur_q / 12;
		wt[1] = blur_q / 6;
		wt[2] = ONE_Q16 - blur_q;
		rr[0] = (r + h - 1) % h;
		rr[1] = r;
		rr[2] = (r + 1) % h;
		cc[0] = (c + w - 1) % w;
		cc[1] = c;
		cc[2] = (c + 1) % w;
		acc = 0;
		for (int a = 0; a < 3; a++) begin
			for (int k = 0; k < 3; k++) begin
				kind = (a == 1) + (k == 1);
				acc += (cell_mem[rr[a]*GRID_COLS + cc[k]] * wt[kind]) >> 16;
			end
		end
		if (acc > SAT_MAX)
			acc = SAT_MAX;
		res.rw      = r;
		res.cl      = c;
		res.blurred = typed ? typed_val : acc[DATA_W-1:0];
		blur_expect.push_back(res);
	endtask

	task automatic send_request(input action_t act, input logic [COORD_W-1:0] r,
			input logic [COORD_W-1:0] c, input logic [DATA_W-1:0] v,
			input bit typed = 1'b0, input logic [DATA_W-1:0] typed_val = '0);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		in_valid   = 1'b1;
		action     = act;
		row        = r;
		col        = c;
		cell_value = v;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_blur(act, r, c, v, typed, typed_val);
	endtask

	task automatic drain_results;
		@(negedge clk);
		in_valid = 1'b0;
		while (blur_expect.size() != 0)
			@(posedge clk);
	endtask

	// registers only change with the block idle
	task automatic write_register(input cfg_idx_t idx, input logic [DATA_W-1:0] data);
		drain_results();
		repeat (SETTLE_TICKS) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			CFG_GRID_HEIGHT: rows_q = data[DIM_W-1:0];
			CFG_GRID_WIDTH:  cols_q = data[DIM_W-1:0];
			CFG_BLUR_AMOUNT: blur_q = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	initial begin
		cycles = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	// result side
	initial begin
		blur_result_t exp_res;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (blur_expect.size() == 0) begin
					$display("%0t unexpected result row %0d col %0d value %h",
						$time, out_row, out_col, blurred_value);
					fails++;
				end else begin
					exp_res = blur_expect.pop_front();
					if (out_row !== exp_res.rw) begin
						$display("%0t out_row expected %0d got %0d", $time, exp_res.rw, out_row);
						fails++;
					end
					if (out_col !== exp_res.cl) begin
						$display("%0t out_col expected %0d got %0d", $time, exp_res.cl, out_col);
						fails++;
					end
					if (blurred_value !== exp_res.blurred) begin
						$display("%0t blurred_value expected %h got %h",
							$time, exp_res.blurred, blurred_value);
						fails++;
					end
				end
			end
		end
	end

	initial begin
		int            h;
		int            w;
		logic [3:0]    r;
		logic [3:0]    c;
		logic [15:0]   ph;
		logic [15:0]   pw;
		logic [15:0]   pb;
		action_t       act;

		fails         = 0;
		send_idle_pct = 17;
		recv_idle_pct = 53;
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		in_valid      = 1'b0;
		action        = 1'b0;
		row           = '0;
		col           = '0;
		cell_value    = '0;
		rows_q        = RST_GRID_HEIGHT;
		cols_q        = RST_GRID_WIDTH;
		blur_q        = RST_BLUR_AMOUNT;
		foreach (cell_mem[i])
			cell_mem[i] = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: full neighbourhood of (0,0) at full scale
		add_req(ACT_WRITE, 15, 15, 16'hFFFF);
		add_req(ACT_WRITE, 15, 0, 16'hFFFF);
		add_req(ACT_WRITE, 15, 1, 16'hFFFF);
		add_req(ACT_WRITE, 0, 15, 16'hFFFF);
		add_req(ACT_WRITE, 0, 0, 16'hFFFF);
		add_req(ACT_WRITE, 0, 1, 16'hFFFF);
		add_req(ACT_WRITE, 1, 15, 16'hFFFF);
		add_req(ACT_WRITE, 1, 0, 16'hFFFF);
		add_req(ACT_WRITE, 1, 1, 16'hFFFF);
		add_req(ACT_READ, 0, 0, 0, 1'b1, 65523);
		add_req(ACT_WRITE, 0, 0, 16'h0000);
		add_req(ACT_READ, 0, 0, 16'h5A5A);
		// height 0 clamps to one row; width data carries junk above bit 4
		add_reg(CFG_GRID_HEIGHT, 0);
		add_reg(CFG_GRID_WIDTH, 16'hFFF0);
		add_req(ACT_WRITE, 0, 0, 16'h8001);
		add_req(ACT_READ, 1, 0, 0);
		add_req(ACT_WRITE, 3, 5, 16'h1234);
		add_req(ACT_READ, 0, 0, 0);
		// no blur: centre weight exactly one
		add_reg(CFG_BLUR_AMOUNT, 0);
		add_req(ACT_READ, 0, 0, 16'hFFFF, 1'b1, 16'h8001);
		add_reg(CFG_UNUSED, 16'hFFFF);
		add_reg(CFG_BLUR_AMOUNT, 16'hFFFF);
		add_reg(CFG_GRID_HEIGHT, 31);
		add_reg(CFG_GRID_WIDTH, 1);
		add_req(ACT_READ, 0, 0, 0);
		add_req(ACT_READ, 0, 1, 0);
		add_req(ACT_WRITE, 15, 15, 0);
		add_reg(CFG_GRID_WIDTH, 2);
		add_req(ACT_READ, 0, 0, 0);

		foreach (directed[i]) begin
			if (directed[i].is_reg)
				write_register(directed[i].idx, directed[i].data);
			else
				send_request(directed[i].act, directed[i].r, directed[i].c, directed[i].v,
					directed[i].typed, directed[i].typed_val);
		end

		// fill the whole store so that any later read is defined
		write_register(CFG_GRID_HEIGHT, DATA_W'(GRID_ROWS));
		write_register(CFG_GRID_WIDTH, DATA_W'(GRID_COLS));
		for (int i = 0; i < GRID_ROWS*GRID_COLS; i++)
			send_request(ACT_WRITE, COORD_W'(i / GRID_COLS), COORD_W'(i % GRID_COLS),
				DATA_W'($urandom_range(0, 65535)));

		for (int p = 0; p < 9; p++) begin
			case (p)
				0: begin ph = 16;       pw = 16;       pb = DATA_W'($urandom_range(0, 65535)); end
				1: begin ph = 1;        pw = 1;        pb = 0;                        end
				2: begin ph = 2;        pw = 2;        pb = 16'hFFFF;                 end
				3: begin ph = 16'hFFE0; pw = 16'h0013; pb = DATA_W'($urandom_range(0, 65535)); end
				4: begin ph = 3;        pw = 16;       pb = 1;                        end
				5: begin ph = 16;       pw = 5;        pb = DATA_W'($urandom_range(0, 65535)); end
				6: begin ph = 7;        pw = 9;        pb = 16'hFFFE;                 end
				7: begin ph = 31;       pw = 0;        pb = DATA_W'($urandom_range(0, 65535)); end
				default: begin ph = 16; pw = 16;       pb = 16'hFFFF;                 end
			endcase
			if (p == 3) begin
				send_idle_pct = 53;
				recv_idle_pct = 17;
			end else if (p == 6) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			write_register(CFG_GRID_HEIGHT, ph);
			write_register(CFG_GRID_WIDTH, pw);
			write_register(CFG_BLUR_AMOUNT, pb);
			if (p == 5)
				write_register(CFG_UNUSED, DATA_W'($urandom_range(0, 65535)));
			h = dim_in_use(rows_q, GRID_ROWS);
			w = dim_in_use(cols_q, GRID_COLS);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				// hold the sender until the block has emptied
				if (p == 4 && n == PHASE_ITEMS / 2)
					drain_results();
				act = $urandom_range(0, 1) ? ACT_READ : ACT_WRITE;
				r = COORD_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
					: $urandom_range(0, h - 1));
				c = COORD_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 15)
					: $urandom_range(0, w - 1));
				send_request(act, r, c, DATA_W'($urandom_range(0, 65535)));
			end
		end

		drain_results();
		repeat (SETTLE_TICKS) @(posedge clk);
		if (fails == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== files.f =====
src/t3blur_pkg.sv
src/t3blur_ctrl.sv
src/t3blur_dp.sv
src/toroidal_3x3_blur_core.sv
tb/sv/testbench.sv
